/* rtl/core/bas_pkg.sv */
package bas_pkg;

    localparam int DATA_W = 32;

    // s_tuser kind codes
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

    // config register indexes
    localparam logic [1:0] CFG_INPUT_OFFSET  = 2'd0;
    localparam logic [1:0] CFG_OUTPUT_OFFSET = 2'd1;
    localparam logic [1:0] CFG_GAIN          = 2'd2;

    localparam logic signed [DATA_W-1:0] GAIN_RESET = 32'sd65536;   // 1.0 in Q16.16

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_DIFF,
        ST_MUL,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

/* rtl/core/bas_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
module bas_div #(
    parameter int SUM_W = 48,
    parameter int CNT_W = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [SUM_W-1:0]         num,
    input  logic [CNT_W-1:0]         den,
    output logic [SUM_W-1:0]         quot,
    output bas_pkg::div_stat_t       stat
);

    localparam int CW = $clog2(SUM_W + 1);

    logic [SUM_W-1:0] num_reg, num_next;
    logic [CNT_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] den_reg;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [CNT_W:0]   trial;
    logic [CNT_W:0]   trial_sub;
    logic             ge;

    assign trial     = {rem_reg, num_reg[SUM_W-1]};
    assign trial_sub = trial - {1'b0, den_reg};
    assign ge        = (trial >= {1'b0, den_reg});

    always_comb begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            num_next  = num;
            rem_next  = '0;
            cnt_next  = CW'(SUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            num_next = {num_reg[SUM_W-2:0], ge};
            rem_next = ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        num_reg <= num_next;
        rem_reg <= rem_next;
        if (start) begin
            den_reg <= den;
        end
    end

    assign quot      = num_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("divider restarted while busy");

    a_busy_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> cnt_reg != '0)
        else $error("divider busy with zero step count");

    a_done_end: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("divider done without finishing a run");

endmodule

/* rtl/core/block_average_scale_offset.sv */
// Channel | Dir | tdata                   | tuser (bit 0 up)       | Handshake
// s_      | in  | [31:0] sample_value     | [0] kind (1 = tick)    | s_tvalid/s_tready
// m_      | out | [31:0] result_value     | [0] was_empty,         | m_tvalid/m_tready
//         |     |                         | [1] saturated          |
// cfg_    | in  | cfg_index[1:0], cfg_data[31:0]                   | cfg_valid/cfg_ready
//
// Samples are taken back to back while no tick is in flight. A tick runs the
// bit-serial divider, then the difference and product steps; an empty tick skips
// them. s_tready is low while a tick is in flight.
// One result register: the next samples are taken while a result waits.
// Reset (aresetn, synchronous) clears sum, count, drop flag, registers, handshake.
module block_average_scale_offset #(
    parameter int COUNT_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [31:0] sample_value
    input  logic [0:0]  s_tuser,    // [0] kind

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [31:0] result_value
    output logic [1:0]  m_tuser,    // [0] was_empty, [1] saturated

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int DW    = bas_pkg::DATA_W;
    localparam int SUM_W = DW + COUNT_BITS;
    localparam int PW    = 2 * DW + 1;       // product width
    localparam int TW    = 43;               // clamped value plus offset
    localparam logic [COUNT_BITS-1:0] FULL = {COUNT_BITS{1'b1}};
    localparam logic signed [PW-1:0] LIM_HI = PW'(1) <<< 40;
    localparam logic signed [PW-1:0] LIM_LO = -LIM_HI;
    localparam logic signed [TW-1:0] SAT_HI = TW'(32'sh7FFF_FFFF);
    localparam logic signed [TW-1:0] SAT_LO = -TW'(33'sh0_8000_0000);

    bas_pkg::state_t state_reg, state_next;

    // configuration
    logic signed [DW-1:0] ioff_reg, ooff_reg, gain_reg;

    // accumulator
    logic signed [SUM_W-1:0]  sum_reg;
    logic [COUNT_BITS-1:0]    count_reg;
    logic                     dropped_reg;

    // per-tick working registers
    logic                     neg_reg;
    logic                     empty_reg;
    logic                     drop_snap_reg;
    logic signed [DW:0]       diff_reg;
    logic signed [PW-1:0]     prod_reg;

    // result register
    logic                     m_tvalid_reg, m_tvalid_next;
    logic [DW-1:0]            m_data_reg;
    logic [1:0]               m_user_reg;

    logic                     s_acc, take_sample, take_tick, is_empty, out_free, load_out;
    logic [SUM_W-1:0]         sum_mag;
    logic [SUM_W-1:0]         quot;
    bas_pkg::div_stat_t       div_stat;
    logic                     div_start;

    logic signed [DW:0]       mean;
    logic signed [DW:0]       diff_next;
    logic signed [PW-1:0]     prod_next;
    logic signed [PW-1:0]     q;
    logic signed [TW-1:0]     tot;
    logic                     q_hi, q_lo, pos_sat, neg_sat;
    logic [DW-1:0]            res_val;
    logic                     res_sat;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == bas_pkg::ST_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign take_sample = s_acc && (s_tuser[0] == bas_pkg::KIND_SAMPLE);
    assign take_tick   = s_acc && (s_tuser[0] == bas_pkg::KIND_TICK);
    assign is_empty    = (count_reg == '0);
    assign out_free    = !m_tvalid_reg || m_tready;
    assign load_out    = (state_reg == bas_pkg::ST_FIN) && out_free;

    // divider gets |sum| / count; the sign is put back afterwards
    assign sum_mag   = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign div_start = take_tick && !is_empty;

    bas_div #(
        .SUM_W (SUM_W),
        .CNT_W (COUNT_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (sum_mag),
        .den     (count_reg),
        .quot    (quot),
        .stat    (div_stat)
    );

    // mean truncated toward zero, then offset-corrected (exact in 33 bits)
    assign mean      = neg_reg ? -$signed(quot[DW:0]) : $signed(quot[DW:0]);
    assign diff_next = mean - {ioff_reg[DW-1], ioff_reg};
    assign prod_next = $signed({{(DW+1){gain_reg[DW-1]}}, gain_reg})
                     * $signed({{DW{diff_reg[DW]}}, diff_reg});

    // floor shift, clamp, offset, saturate
    assign q       = prod_reg >>> FRAC_BITS;
    assign q_hi    = (q > LIM_HI);
    assign q_lo    = (q < LIM_LO);
    assign tot     = $signed(q[TW-1:0]) + TW'(ooff_reg);
    assign pos_sat = q_hi || (!q_lo && (tot > SAT_HI));
    assign neg_sat = q_lo || (!q_hi && (tot < SAT_LO));

    always_comb begin
        if (empty_reg) begin
            res_val = ooff_reg;
            res_sat = drop_snap_reg;
        end else if (pos_sat) begin
            res_val = 32'h7FFF_FFFF;
            res_sat = 1'b1;
        end else if (neg_sat) begin
            res_val = 32'h8000_0000;
            res_sat = 1'b1;
        end else begin
            res_val = tot[DW-1:0];
            res_sat = drop_snap_reg;
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bas_pkg::ST_IDLE: begin
                if (take_tick) begin
                    state_next = is_empty ? bas_pkg::ST_FIN : bas_pkg::ST_DIV;
                end
            end
            bas_pkg::ST_DIV: begin
                if (div_stat.done) begin
                    state_next = bas_pkg::ST_DIFF;
                end
            end
            bas_pkg::ST_DIFF: state_next = bas_pkg::ST_MUL;
            bas_pkg::ST_MUL:  state_next = bas_pkg::ST_FIN;
            bas_pkg::ST_FIN: begin
                if (out_free) begin
                    state_next = bas_pkg::ST_IDLE;
                end
            end
            default: state_next = bas_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (load_out) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= bas_pkg::ST_IDLE;
            ioff_reg     <= '0;
            ooff_reg     <= '0;
            gain_reg     <= bas_pkg::GAIN_RESET;
            sum_reg      <= '0;
            count_reg    <= '0;
            dropped_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    bas_pkg::CFG_INPUT_OFFSET:  ioff_reg <= cfg_data;
                    bas_pkg::CFG_OUTPUT_OFFSET: ooff_reg <= cfg_data;
                    bas_pkg::CFG_GAIN:          gain_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (take_sample) begin
                if (count_reg == FULL) begin
                    dropped_reg <= 1'b1;
                end else begin
                    sum_reg   <= sum_reg + SUM_W'($signed(s_tdata));
                    count_reg <= count_reg + 1'b1;
                end
            end else if (take_tick) begin
                sum_reg     <= '0;
                count_reg   <= '0;
                dropped_reg <= 1'b0;
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge aclk) begin
        if (take_tick) begin
            neg_reg       <= sum_reg[SUM_W-1];
            empty_reg     <= is_empty;
            drop_snap_reg <= dropped_reg;
        end
        if (state_reg == bas_pkg::ST_DIFF) begin
            diff_reg <= diff_next;
        end
        if (state_reg == bas_pkg::ST_MUL) begin
            prod_reg <= prod_next;
        end
        if (load_out) begin
            m_data_reg <= res_val;
            m_user_reg <= {res_sat, empty_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    a_busy_no_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != bas_pkg::ST_IDLE) |-> !s_tready)
        else $error("input ready while a tick is in flight");

    a_drop_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (take_sample && count_reg == FULL) |=> dropped_reg && count_reg == FULL)
        else $error("sample at full count not dropped");

    a_tick_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        take_tick |=> (count_reg == '0) && (sum_reg == '0) && !dropped_reg)
        else $error("tick did not clear the accumulator");

    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> state_reg == bas_pkg::ST_DIV)
        else $error("divider finished outside the divide step");

endmodule
